>>> sv/lambda_branching_factor_assert.svh
// Assertion macros shared by the lambda branching factor RTL.
`ifndef LAMBDA_BRANCHING_FACTOR_ASSERT_SVH
`define LAMBDA_BRANCHING_FACTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LBF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lambda_branching_factor: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lambda_branching_factor: next-cycle check failed");

`endif

>>> sv/lbf_pkg.sv
// ----------------------------------------------------------------------------
// lbf_pkg
// Types and fixed constants of the lambda branching factor block.
// ----------------------------------------------------------------------------
package lbf_pkg;

   localparam int TRAIL_W    = 32;           // Q16.16 trail value
   localparam int FRAC_W     = 17;           // Q1.16 cutoff fraction
   localparam int MEAN_W     = 22;           // Q6.16 mean
   localparam int NODE_W     = 16;
   localparam int LIMIT_W    = FRAC_W + TRAIL_W;
   localparam int ABOVE_W    = TRAIL_W + 16;
   localparam int DIVIDEND_W = MEAN_W + 16;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd3277;
   localparam logic [MEAN_W-1:0] TOTAL_MAX  = 22'h3FFFFF;
   localparam logic [MEAN_W-1:0] MEAN_MAX   = 22'h3FFFFF;
   localparam logic [MEAN_W-1:0] MEAN_FLOOR = 22'd131072;

   typedef struct packed {
      logic [TRAIL_W-1:0] trail_value;
      logic               last_of_node;
      logic               last_of_set;
   } req_type;

   typedef struct packed {
      logic [MEAN_W-1:0] mean_branches;
      logic [NODE_W-1:0] nodes_seen;
   } rsp_type;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MULT = 6'b000010,
      S_SCAN = 6'b000100,
      S_SUM  = 6'b001000,
      S_DIV  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

endpackage

>>> sv/lambda_branching_factor.sv
// A value that does not close a node is taken while idle and leaves busy low.
// A value that closes a node holds busy through a multiply, a scan that reads
// every stored value from the candidate buffer (registered read data), a wait
// for the scan to drain, and an accumulate. A value that closes the set adds
// the divide (38 quotient bits plus the done flag) and a state that registers
// the result, which is strobed for 1 cycle. No value is taken while busy.
// Reset (synchronous): fraction 3277, totals and node state cleared; buffer not cleared.
// ----------------------------------------------------------------------------
// lambda_branching_factor
// Per-node count of candidate trails above min + fraction*(max-min), averaged
// over the nodes of a set and clamped to at least 2.0.
// ----------------------------------------------------------------------------
module lambda_branching_factor #(
   parameter int MAX_DEPTH = 32,
   parameter int MAX_NODES = 65535
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lbf_pkg::req_type           req_data,
   output logic                       rsp_strobe,
   output lbf_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lbf_pkg::FRAC_W-1:0] csr_wdata
);

   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int FW = $clog2(MAX_DEPTH + 1);
   localparam logic [FW-1:0] DEPTH_FILL = FW'(MAX_DEPTH);
   localparam logic [lbf_pkg::NODE_W-1:0] NODE_LIMIT = lbf_pkg::NODE_W'(MAX_NODES);

   lbf_pkg::state_type             state_ff, state_in;
   logic [FW-1:0]                  fill_ff, fill_in;
   logic [lbf_pkg::TRAIL_W-1:0]    min_ff, min_in;
   logic [lbf_pkg::TRAIL_W-1:0]    max_ff, max_in;
   logic [lbf_pkg::LIMIT_W-1:0]    limit_ff, limit_in;
   logic [FW-1:0]                  issue_ff, issue_in;
   logic                           pend_ff, pend_in;
   logic [FW-1:0]                  count_ff, count_in;
   logic [lbf_pkg::MEAN_W-1:0]     btot_ff, btot_in;
   logic [lbf_pkg::NODE_W-1:0]     ntot_ff, ntot_in;
   logic                           set_end_ff, set_end_in;
   logic                           strobe_ff, strobe_in;
   lbf_pkg::rsp_type               rsp_ff, rsp_in;
   logic [lbf_pkg::FRAC_W-1:0]     frac_ff;
   logic [lbf_pkg::DIVIDEND_W-1:0] q_hold_ff, q_hold_in;

   logic                           accept;
   logic                           wr_en;
   logic                           rd_en;
   logic [AW-1:0]                  rd_addr;
   logic [lbf_pkg::TRAIL_W-1:0]    rd_data;
   logic                           div_start;
   logic                           div_done;
   logic [lbf_pkg::DIVIDEND_W-1:0] div_quo;
   logic [lbf_pkg::ABOVE_W:0]      above;
   logic [lbf_pkg::MEAN_W:0]       total_sum;
   logic [lbf_pkg::MEAN_W-1:0]     mean;

   assign busy      = (state_ff != lbf_pkg::S_IDLE);
   assign accept    = start & ~busy;
   assign csr_ready = ~busy;
   assign wr_en     = accept & (fill_ff < DEPTH_FILL);

   lbf_store #(
      .DEPTH (MAX_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_data.trail_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lbf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({btot_in, 16'h0000}),
      .divisor  (ntot_in),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      limit_in   = limit_ff;
      issue_in   = issue_ff;
      pend_in    = 1'b0;
      count_in   = count_ff;
      btot_in    = btot_ff;
      ntot_in    = ntot_ff;
      set_end_in = set_end_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      q_hold_in  = q_hold_ff;
      div_start  = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = issue_ff[AW-1:0];
      // (value - min) * 2^16, widened by one bit to line up with the limit
      above      = {1'b0, rd_data - min_ff, 16'h0000};
      total_sum  = {1'b0, btot_ff} + (lbf_pkg::MEAN_W + 1)'(count_ff);
      if (q_hold_ff > lbf_pkg::DIVIDEND_W'(lbf_pkg::MEAN_MAX)) begin
         mean = lbf_pkg::MEAN_MAX;
      end else if (q_hold_ff < lbf_pkg::DIVIDEND_W'(lbf_pkg::MEAN_FLOOR)) begin
         mean = lbf_pkg::MEAN_FLOOR;
      end else begin
         mean = q_hold_ff[lbf_pkg::MEAN_W-1:0];
      end

      unique case (state_ff)
         lbf_pkg::S_IDLE: begin
            if (accept) begin
               if (fill_ff < DEPTH_FILL) begin
                  fill_in = fill_ff + 1'b1;
                  if (req_data.trail_value < min_ff) begin
                     min_in = req_data.trail_value;
                  end
                  if (req_data.trail_value > max_ff) begin
                     max_in = req_data.trail_value;
                  end
               end
               if (req_data.last_of_node) begin
                  set_end_in = req_data.last_of_set;
                  state_in   = lbf_pkg::S_MULT;
               end
            end
         end
         lbf_pkg::S_MULT: begin
            limit_in = lbf_pkg::LIMIT_W'(frac_ff) * lbf_pkg::LIMIT_W'(max_ff - min_ff);
            issue_in = '0;
            count_in = '0;
            state_in = lbf_pkg::S_SCAN;
         end
         lbf_pkg::S_SCAN: begin
            if (issue_ff < fill_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end
            if (pend_ff && (above > limit_ff)) begin
               count_in = count_ff + 1'b1;
            end
            if ((issue_ff == fill_ff) && !pend_ff) begin
               state_in = lbf_pkg::S_SUM;
            end
         end
         lbf_pkg::S_SUM: begin
            if (total_sum > (lbf_pkg::MEAN_W + 1)'(lbf_pkg::TOTAL_MAX)) begin
               btot_in = lbf_pkg::TOTAL_MAX;
            end else begin
               btot_in = total_sum[lbf_pkg::MEAN_W-1:0];
            end
            if (ntot_ff < NODE_LIMIT) begin
               ntot_in = ntot_ff + 1'b1;
            end
            fill_in = '0;
            min_in  = '1;
            max_in  = '0;
            if (set_end_ff) begin
               div_start = 1'b1;
               state_in  = lbf_pkg::S_DIV;
            end else begin
               state_in  = lbf_pkg::S_IDLE;
            end
         end
         lbf_pkg::S_DIV: begin
            if (div_done) begin
               q_hold_in = div_quo;
               state_in  = lbf_pkg::S_OUT;
            end
         end
         lbf_pkg::S_OUT: begin
            rsp_in.mean_branches = mean;
            rsp_in.nodes_seen    = ntot_ff;
            strobe_in            = 1'b1;
            btot_in              = '0;
            ntot_in              = '0;
            state_in             = lbf_pkg::S_IDLE;
         end
         default: begin
            state_in = lbf_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lbf_pkg::S_IDLE;
         fill_ff    <= '0;
         min_ff     <= '1;
         max_ff     <= '0;
         pend_ff    <= 1'b0;
         btot_ff    <= '0;
         ntot_ff    <= '0;
         set_end_ff <= 1'b0;
         strobe_ff  <= 1'b0;
         frac_ff    <= lbf_pkg::FRAC_RESET;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         pend_ff    <= pend_in;
         btot_ff    <= btot_in;
         ntot_ff    <= ntot_in;
         set_end_ff <= set_end_in;
         strobe_ff  <= strobe_in;
         if (csr_valid && csr_ready) begin
            frac_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      limit_ff  <= limit_in;
      issue_ff  <= issue_in;
      count_ff  <= count_in;
      rsp_ff    <= rsp_in;
      q_hold_ff <= q_hold_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

`include "lambda_branching_factor_assert.svh"

   `LBF_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= DEPTH_FILL)
   `LBF_ASSERT_NOW(a_min_le_max, clock, reset, fill_ff != '0, min_ff <= max_ff)
   `LBF_ASSERT_NOW(a_issue_bound, clock, reset, state_ff == lbf_pkg::S_SCAN, issue_ff <= fill_ff)
   `LBF_ASSERT_NEXT(a_set_to_div, clock, reset, (state_ff == lbf_pkg::S_SUM) && set_end_ff, state_ff == lbf_pkg::S_DIV)

endmodule

>>> sv/lbf_store.sv
// ----------------------------------------------------------------------------
// lbf_store
// Candidate buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbf_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [lbf_pkg::TRAIL_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [lbf_pkg::TRAIL_W-1:0] rd_data
);

   logic [lbf_pkg::TRAIL_W-1:0] mem [DEPTH];
   logic [lbf_pkg::TRAIL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lbf_div.sv
// ----------------------------------------------------------------------------
// lbf_div
// Restoring divider, one quotient bit per cycle; 16-bit divisor.
// ----------------------------------------------------------------------------
module lbf_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lbf_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [lbf_pkg::NODE_W-1:0]     divisor,
   output logic                           done,
   output logic [lbf_pkg::DIVIDEND_W-1:0] quotient
);

   localparam logic [lbf_pkg::DIV_CNT_W-1:0] LAST_STEP =
      lbf_pkg::DIV_CNT_W'(lbf_pkg::DIVIDEND_W - 1);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [lbf_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [lbf_pkg::NODE_W-1:0]      den_ff, den_in;
   logic [lbf_pkg::NODE_W-1:0]      rem_ff, rem_in;
   logic [lbf_pkg::DIVIDEND_W-1:0]  quo_ff, quo_in;
   logic [lbf_pkg::NODE_W:0]        trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[lbf_pkg::DIVIDEND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits NODE_W bits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = lbf_pkg::NODE_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[lbf_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[lbf_pkg::NODE_W-1:0];
            quo_in = {quo_ff[lbf_pkg::DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the lambda branching factor block: streams of candidate trails are
// sent node by node, an in-bench predictor tracks the per-node cutoff count
// and the running totals, and every mean strobed out is compared with it.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLK_PERIOD   = 12;
   localparam int MAX_DEPTH    = 32;
   localparam int MAX_NODES    = 65535;
   localparam int SETTLE_PAUSE = 100;   // covers the longest close: a full buffer scan plus the divide
   localparam int PHASE_ITEMS  = 150;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   lbf_pkg::req_type            req_data = '0;
   logic                        rsp_strobe;
   lbf_pkg::rsp_type            rsp_data;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [lbf_pkg::FRAC_W-1:0]  csr_wdata = '0;

   // predictor state
   logic [lbf_pkg::TRAIL_W-1:0] trail_buf [MAX_DEPTH];
   int unsigned                 buf_fill = 0;
   logic [lbf_pkg::TRAIL_W-1:0] node_lo = '1;
   logic [lbf_pkg::TRAIL_W-1:0] node_hi = '0;
   logic [lbf_pkg::MEAN_W-1:0]  branch_sum = '0;
   logic [lbf_pkg::NODE_W-1:0]  node_count = '0;
   logic [lbf_pkg::FRAC_W-1:0]  fraction = lbf_pkg::FRAC_RESET;

   lbf_pkg::rsp_type            pending_means[$];
   int unsigned                 error_count = 0;
   bit                          idle_enabled = 1'b1;

   lambda_branching_factor #(
      .MAX_DEPTH(MAX_DEPTH),
      .MAX_NODES(MAX_NODES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // Folds one accepted trail into the node; on a node close counts the
   // values strictly above min + fraction*(max-min), on a set close queues
   // the expected mean.
   task automatic predict_branching(input lbf_pkg::req_type item);
      logic [63:0]                  span_limit;
      logic [63:0]                  lifted;
      logic [lbf_pkg::MEAN_W:0]     sum_wide;
      logic [lbf_pkg::MEAN_W+15:0]  mean_wide;
      int unsigned                  count;
      lbf_pkg::rsp_type             result;
      if (buf_fill < MAX_DEPTH) begin
         trail_buf[buf_fill] = item.trail_value;
         buf_fill++;
         if (item.trail_value < node_lo) node_lo = item.trail_value;
         if (item.trail_value > node_hi) node_hi = item.trail_value;
      end
      if (!item.last_of_node) return;
      span_limit = 64'(fraction) * (64'(node_hi) - 64'(node_lo));
      count = 0;
      for (int k = 0; k < buf_fill; k++) begin
         lifted = (64'(trail_buf[k]) - 64'(node_lo)) << 16;
         if (lifted > span_limit) count++;
      end
      sum_wide = {1'b0, branch_sum} + (lbf_pkg::MEAN_W + 1)'(count);
      branch_sum = (sum_wide > {1'b0, lbf_pkg::TOTAL_MAX}) ? lbf_pkg::TOTAL_MAX
                                                          : sum_wide[lbf_pkg::MEAN_W-1:0];
      if (node_count < MAX_NODES) node_count++;
      buf_fill = 0;
      node_lo = '1;
      node_hi = '0;
      if (!item.last_of_set) return;
      mean_wide = {branch_sum, 16'h0000} / (lbf_pkg::MEAN_W + 16)'(node_count);
      if (mean_wide < (lbf_pkg::MEAN_W + 16)'(lbf_pkg::MEAN_FLOOR))
         mean_wide = (lbf_pkg::MEAN_W + 16)'(lbf_pkg::MEAN_FLOOR);
      if (mean_wide > (lbf_pkg::MEAN_W + 16)'(lbf_pkg::MEAN_MAX))
         mean_wide = (lbf_pkg::MEAN_W + 16)'(lbf_pkg::MEAN_MAX);
      result.mean_branches = mean_wide[lbf_pkg::MEAN_W-1:0];
      result.nodes_seen = node_count;
      pending_means.push_back(result);
      branch_sum = '0;
      node_count = '0;
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!idle_enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // start is left high after acceptance so back-to-back requests never
   // drop it; whoever goes next lowers it in the same step if needed
   task automatic send_trail(input logic [lbf_pkg::TRAIL_W-1:0] value, input logic node_end,
                             input logic set_end);
      int unsigned      gap;
      lbf_pkg::req_type item;
      gap = pick_gap();
      item.trail_value = value;
      item.last_of_node = node_end;
      item.last_of_set = set_end;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      predict_branching(item);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE_PAUSE) @(posedge clock);
   endtask

   task automatic write_fraction(input logic [lbf_pkg::FRAC_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      fraction = value;
   endtask

   task automatic send_node(input int unsigned length, input logic closes_set);
      int unsigned                 mode;
      logic [lbf_pkg::TRAIL_W-1:0] base;
      logic [lbf_pkg::TRAIL_W-1:0] value;
      logic                        last;
      mode = $urandom_range(0, 3);
      base = $urandom();
      for (int unsigned i = 0; i < length; i++) begin
         case (mode)
            0: value = $urandom();
            1: value = base + $urandom_range(0, 15);
            2: begin
               case ($urandom_range(0, 2))
                  0: value = '0;
                  1: value = '1;
                  default: value = $urandom();
               endcase
            end
            default: value = base;
         endcase
         last = (i == length - 1);
         // stray set marks on values that do not close the node
         send_trail(value, last, last ? closes_set : ($urandom_range(0, 9) == 0));
      end
   endtask

   always @(posedge clock) begin
      lbf_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_means.size() == 0) begin
            $display("%0t: unexpected result mean %h nodes %0d", $time,
                     rsp_data.mean_branches, rsp_data.nodes_seen);
            error_count++;
         end else begin
            want = pending_means.pop_front();
            if (rsp_data.mean_branches !== want.mean_branches) begin
               $display("%0t: mean_branches expected %h actual %h", $time,
                        want.mean_branches, rsp_data.mean_branches);
               error_count++;
            end
            if (rsp_data.nodes_seen !== want.nodes_seen) begin
               $display("%0t: nodes_seen expected %0d actual %0d", $time,
                        want.nodes_seen, rsp_data.nodes_seen);
               error_count++;
            end
         end
      end
   end

   task automatic test_extreme_values();
      send_trail(32'h0000_0000, 1'b0, 1'b0);
      send_trail(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_trail(32'h8000_0000, 1'b0, 1'b0);
      send_trail(32'h0000_0001, 1'b0, 1'b0);
      send_trail(32'hFFFF_FFFE, 1'b1, 1'b1);
      send_trail(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_trail(32'hFFFF_FFFF, 1'b1, 1'b0);
      // set mark alone must not close anything
      send_trail(32'h0000_0005, 1'b0, 1'b1);
      send_trail(32'h0000_0007, 1'b1, 1'b1);
   endtask

   task automatic test_exact_cutoff();
      write_fraction(17'h0_8000);
      // cutoff lands exactly on 50, which must not count
      send_trail(32'd0, 1'b0, 1'b0);
      send_trail(32'd100, 1'b0, 1'b0);
      send_trail(32'd50, 1'b0, 1'b0);
      send_trail(32'd51, 1'b0, 1'b0);
      send_trail(32'd60, 1'b0, 1'b0);
      send_trail(32'd70, 1'b1, 1'b1);
   endtask

   task automatic test_fraction_limits();
      write_fraction(17'h0_0000);
      send_trail(32'd10, 1'b0, 1'b0);
      send_trail(32'd10, 1'b0, 1'b0);
      send_trail(32'd20, 1'b0, 1'b0);
      send_trail(32'd20, 1'b0, 1'b0);
      send_trail(32'd20, 1'b1, 1'b1);
      write_fraction(17'h1_0000);
      send_trail(32'd0, 1'b0, 1'b0);
      send_trail(32'd100, 1'b0, 1'b0);
      send_trail(32'd100, 1'b0, 1'b0);
      send_trail(32'd50, 1'b1, 1'b1);
      write_fraction(17'h1_FFFF);
      send_trail(32'd0, 1'b0, 1'b0);
      send_trail(32'd100, 1'b0, 1'b0);
      send_trail(32'd50, 1'b1, 1'b1);
   endtask

   task automatic test_random_sets();
      logic [lbf_pkg::FRAC_W-1:0] setting;
      int unsigned                items;
      int unsigned                nodes;
      int unsigned                length;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: setting = lbf_pkg::FRAC_RESET;
            1: setting = 17'h0_0000;
            2: setting = 17'h1_0000;
            3: setting = 17'h1_FFFF;
            4: setting = lbf_pkg::FRAC_W'($urandom_range(0, 17'h1_FFFF));
            default: setting = lbf_pkg::FRAC_W'($urandom_range(0, 17'h1_0000));
         endcase
         write_fraction(setting);
         idle_enabled = ($urandom_range(0, 3) != 0);
         items = 0;
         while (items < PHASE_ITEMS) begin
            nodes = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
            for (int unsigned n = 0; n < nodes; n++) begin
               // some nodes overrun the candidate buffer
               length = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40)
                                                     : $urandom_range(1, 10);
               send_node(length, n == nodes - 1);
               items += length;
            end
         end
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_extreme_values();
      test_exact_cutoff();
      test_fraction_limits();
      test_random_sets();
      settle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #(CLK_PERIOD * 3_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
